>>> design/q24alu_pkg.sv
package q24alu_pkg;

  // Fixed-point format and divider layout
  localparam int FRAC_BITS  = 8;
  localparam int QUOT_W     = 32 + FRAC_BITS;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = (QUOT_W + DIV_BPS - 1) / DIV_BPS;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Operation codes
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_I2F  = 4'd8,
    OP_F2I  = 4'd9
  } alu_op_t;

  // Request word
  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_req_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               overflow;
    logic               divide_by_zero;
  } alu_rsp_t;

endpackage

>>> design/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU. Takes one request word per cycle on a valid/ready
// channel and returns one result word per request, in order, after it passes two
// front stages, 20 divider stages, a rounding stage and the output register. The
// depth of the pipeline is set by the restoring divider, which resolves two
// of its 40 quotient bits per stage; every operation rides the same pipeline. All
// stages advance together whenever the output register is empty or being taken, so
// the block streams one word per cycle as long as the result side keeps up.
// Products and quotients round to nearest, half away from zero; results that do
// not fit saturate and set overflow; divide by zero returns 0 with its own flag.
module fixed_point_q24_8_alu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  q24alu_pkg::alu_req_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output q24alu_pkg::alu_rsp_t out_word
);
  import q24alu_pkg::*;

  localparam int QW1 = QUOT_W + 1;
  localparam logic [63:0] MUL_HALF = 64'd1 << (FRAC_BITS - 1);

  // Control and early result that travel beside the divider
  typedef struct packed {
    logic [3:0]  op;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [31:0] res;
    logic        ovf;
    logic        dz;
    logic        neg;
    logic        div_en;
  } side_t;

  typedef struct packed {
    logic [31:0]       rem;
    logic [QUOT_W-1:0] num;
    logic [31:0]       mb;
  } div_state_t;

  logic adv;

  logic       s1_valid_r;
  alu_req_t   s1_req_r;

  logic       s2_valid_r;
  side_t      s2_side_r;
  side_t      s2_side_nxt;
  logic [31:0] s2_ma_r;
  logic [31:0] s2_ma_nxt;
  logic [31:0] s2_mb_r;
  logic [31:0] s2_mb_nxt;

  logic [63:0] prod_r;

  logic       dv_valid_r [DIV_STAGES];
  side_t      dv_side_r  [DIV_STAGES];
  side_t      dv_side_nxt[DIV_STAGES];
  div_state_t dv_st_r    [DIV_STAGES];
  div_state_t dv_st_nxt  [DIV_STAGES];
  div_state_t dv_in      [DIV_STAGES];

  logic           rnd_valid_r;
  side_t          rnd_side_r;
  logic [QW1-1:0] rnd_q_r;
  logic [QW1-1:0] rnd_q_nxt;

  logic     out_valid_r;
  alu_rsp_t out_word_r;
  alu_rsp_t out_word_nxt;

  // Whole pipeline moves when the output register can take a word
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Saturate a 33-bit sum to 32 bits; returns {ovf, value}
  function automatic logic [32:0] sat_sum(logic [32:0] sum);
    logic [32:0] r;
    if (sum[32] != sum[31]) begin
      r = {1'b1, (sum[32] ? SAT_MIN : SAT_MAX)};
    end else begin
      r = {1'b0, sum[31:0]};
    end
    return r;
  endfunction

  // Stage 2: compare, simple operations, operand magnitudes
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [FRAC_BITS:0] hi;
    a  = s1_req_r.operand_a;
    b  = s1_req_r.operand_b;
    hi = a[31:31-FRAC_BITS];
    s2_side_nxt        = '0;
    s2_side_nxt.op     = s1_req_r.req_type;
    s2_side_nxt.lt     = a < b;
    s2_side_nxt.eq     = a == b;
    s2_side_nxt.gt     = a > b;
    s2_side_nxt.neg    = a[31] ^ b[31];
    s2_ma_nxt = a[31] ? (~a + 32'd1) : a;
    s2_mb_nxt = b[31] ? (~b + 32'd1) : b;
    unique case (s1_req_r.req_type)
      OP_ADD: {s2_side_nxt.ovf, s2_side_nxt.res} = sat_sum({a[31], a} + {b[31], b});
      OP_SUB: {s2_side_nxt.ovf, s2_side_nxt.res} = sat_sum({a[31], a} - {b[31], b});
      OP_MUL: begin
        // filled in once the product is ready
      end
      OP_DIV: begin
        if (b == 32'sd0) begin
          s2_side_nxt.dz = 1'b1;
        end else begin
          s2_side_nxt.div_en = 1'b1;
        end
      end
      OP_MIN: s2_side_nxt.res = s2_side_nxt.lt ? a : b;
      OP_MAX: s2_side_nxt.res = s2_side_nxt.gt ? a : b;
      OP_INC: {s2_side_nxt.ovf, s2_side_nxt.res} = sat_sum({a[31], a} + 33'd1);
      OP_DEC: {s2_side_nxt.ovf, s2_side_nxt.res} = sat_sum({a[31], a} - 33'd1);
      OP_I2F: begin
        if ((&hi) || !(|hi)) begin
          s2_side_nxt.res = {a[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end else begin
          s2_side_nxt.ovf = 1'b1;
          s2_side_nxt.res = a[31] ? SAT_MIN : SAT_MAX;
        end
      end
      OP_F2I: s2_side_nxt.res = a >>> FRAC_BITS;
      default: s2_side_nxt.res = '0;
    endcase
  end

  // Divider: restoring, DIV_BPS quotient bits per stage
  always_comb begin
    div_state_t st;
    logic [32:0] trial;
    logic        qbit;
    dv_in[0] = '{rem: '0, num: {s2_ma_r, {FRAC_BITS{1'b0}}}, mb: s2_mb_r};
    for (int s = 1; s < DIV_STAGES; s++) begin
      dv_in[s] = dv_st_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      st = dv_in[s];
      for (int k = 0; k < DIV_BPS; k++) begin
        if (s * DIV_BPS + k < QUOT_W) begin
          trial = {st.rem, st.num[QUOT_W-1]};
          if (trial >= {1'b0, st.mb}) begin
            trial = trial - {1'b0, st.mb};
            qbit  = 1'b1;
          end else begin
            qbit  = 1'b0;
          end
          st.rem = trial[31:0];
          st.num = {st.num[QUOT_W-2:0], qbit};
        end
      end
      dv_st_nxt[s] = st;
    end
  end

  // Side chain; multiply result is rounded and merged after the product register
  always_comb begin
    logic [63:0] mul_q;
    side_t       sd;
    mul_q = (prod_r + MUL_HALF) >> FRAC_BITS;
    sd    = dv_side_r[0];
    if (sd.op == OP_MUL) begin
      if (sd.neg) begin
        if (mul_q > 64'h0000_0000_8000_0000) begin
          sd.ovf = 1'b1;
          sd.res = SAT_MIN;
        end else begin
          sd.res = 32'd0 - mul_q[31:0];
        end
      end else begin
        if (mul_q > 64'h0000_0000_7fff_ffff) begin
          sd.ovf = 1'b1;
          sd.res = SAT_MAX;
        end else begin
          sd.res = mul_q[31:0];
        end
      end
    end
    dv_side_nxt[0] = s2_side_r;
    dv_side_nxt[1] = sd;
    for (int s = 2; s < DIV_STAGES; s++) begin
      dv_side_nxt[s] = dv_side_r[s-1];
    end
  end

  // Round quotient: up when twice the remainder reaches the divisor
  always_comb begin
    logic rnd_up;
    rnd_up    = {dv_st_r[DIV_STAGES-1].rem, 1'b0} >= {1'b0, dv_st_r[DIV_STAGES-1].mb};
    rnd_q_nxt = QW1'(dv_st_r[DIV_STAGES-1].num) + QW1'(rnd_up);
  end

  // Output: saturate the quotient and build the result word
  always_comb begin
    out_word_nxt.a_less         = rnd_side_r.lt;
    out_word_nxt.a_equal        = rnd_side_r.eq;
    out_word_nxt.a_greater      = rnd_side_r.gt;
    out_word_nxt.divide_by_zero = rnd_side_r.dz;
    out_word_nxt.overflow       = rnd_side_r.ovf;
    out_word_nxt.result         = rnd_side_r.res;
    if (rnd_side_r.div_en) begin
      if (rnd_side_r.neg) begin
        if (rnd_q_r > QW1'(64'h8000_0000)) begin
          out_word_nxt.overflow = 1'b1;
          out_word_nxt.result   = SAT_MIN;
        end else begin
          out_word_nxt.result   = 32'd0 - rnd_q_r[31:0];
        end
      end else begin
        if (rnd_q_r > QW1'(64'h7fff_ffff)) begin
          out_word_nxt.overflow = 1'b1;
          out_word_nxt.result   = SAT_MAX;
        end else begin
          out_word_nxt.result   = rnd_q_r[31:0];
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      rnd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_valid_r[s] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      dv_valid_r[0] <= s2_valid_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_valid_r[s] <= dv_valid_r[s-1];
      end
      rnd_valid_r <= dv_valid_r[DIV_STAGES-1];
      out_valid_r <= rnd_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r  <= in_word;
      s2_side_r <= s2_side_nxt;
      s2_ma_r   <= s2_ma_nxt;
      s2_mb_r   <= s2_mb_nxt;
      prod_r    <= s2_ma_r * s2_mb_r;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_side_r[s] <= dv_side_nxt[s];
        dv_st_r[s]   <= dv_st_nxt[s];
      end
      rnd_side_r <= dv_side_r[DIV_STAGES-1];
      rnd_q_r    <= rnd_q_nxt;
      out_word_r <= out_word_nxt;
    end
  end

endmodule

>>> design/q24alu_chk.sv
module q24alu_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input q24alu_pkg::alu_rsp_t out_word
);
  import q24alu_pkg::*;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Exactly one comparison flag
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_word.a_less, out_word.a_equal, out_word.a_greater}))
    else $error("comparison flags not one-hot");

  // Divide by zero returns zero without overflow
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.divide_by_zero |-> out_word.result == 32'sd0 && !out_word.overflow)
    else $error("divide by zero result wrong");

  // Overflow always lands on a rail
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.overflow |->
      out_word.result == SAT_MAX || out_word.result == SAT_MIN)
    else $error("overflow without saturated result");

endmodule

bind fixed_point_q24_8_alu q24alu_chk u_q24alu_chk (.*);
